// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the byte translator.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define BTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define BTS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BTS_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/bts_pkg.sv =====
// Types and constants of the byte translator.
// No dependencies.
package bts_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_DEFINE = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    localparam logic [1:0] MODE_TRANSLATE  = 2'd0;
    localparam int         MODE_DELETE_BIT = 1;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_SQUEEZE = 2'd1;
    localparam logic [1:0] REG_NUL     = 2'd2;
    localparam logic [1:0] REG_FILL    = 2'd3;

    localparam int TBL_DEPTH = 256;

    typedef enum logic {
        K_CLEAR,
        K_DATA
    } t_kind;

    typedef struct packed {
        logic [1:0] mode;
        logic       squeeze;
        logic       nul_fill;
        logic [7:0] fill;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       mark;
        logic [7:0] target;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

endpackage

// ===== rtl/byte_translate_squeeze_delete.sv =====
// Byte translator top level: one transaction accepted per cycle while full is low.
// A data byte passes the target RAM read, the lookup queue and the result queue
// before it shows on the result ports and can be popped. full is a credit check
// on the lookup queue; the back end retires one item per cycle while the result
// queue has room. Reset is synchronous: marks, squeeze memory, queues, config and
// valid registers clear at once; target RAM contents stay undefined until defined.
`include "assert_macros.svh"

module byte_translate_squeeze_delete #(
    parameter int MQ_DEPTH = 4,
    parameter int OQ_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_byte_value,
    input  logic [7:0] i_target_value,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);
    import bts_pkg::*;

    localparam int MCW = $clog2(MQ_DEPTH + 1);
    localparam int OCW = $clog2(OQ_DEPTH + 1);
    localparam int IW  = $bits(t_item);

    t_cfg           r_cfg;
    t_stage         s1;
    t_item          mid_item;
    logic [IW-1:0]  mid_rdata;
    logic           mid_empty, mid_full, mid_pop;
    logic [MCW-1:0] mid_count;
    logic [MCW:0]   used;
    logic           out_push, out_full;
    logic [7:0]     out_wdata;
    logic [OCW-1:0] out_count;
    logic           accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:    r_cfg.mode     <= i_cfg_wdata[1:0];
                REG_SQUEEZE: r_cfg.squeeze  <= i_cfg_wdata[0];
                REG_NUL:     r_cfg.nul_fill <= i_cfg_wdata[0];
                REG_FILL:    r_cfg.fill     <= i_cfg_wdata;
                default:     r_cfg          <= r_cfg;
            endcase
        end
    end

    assign used   = {1'b0, mid_count} + (MCW + 1)'(s1.valid);
    assign full   = (used >= (MCW + 1)'(MQ_DEPTH));
    assign accept = push && !full;

    bts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_opcode      (i_opcode),
        .i_byte_value  (i_byte_value),
        .i_target_value(i_target_value),
        .o_s1          (s1)
    );

    bts_fifo #(
        .WIDTH(IW),
        .DEPTH(MQ_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s1.valid),
        .i_wdata(s1.item),
        .i_pop  (mid_pop),
        .o_rdata(mid_rdata),
        .o_empty(mid_empty),
        .o_full (mid_full),
        .o_count(mid_count)
    );

    assign mid_item = t_item'(mid_rdata);

    bts_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (mid_item),
        .i_empty   (mid_empty),
        .i_out_full(out_full),
        .o_pop     (mid_pop),
        .o_push    (out_push),
        .o_byte    (out_wdata)
    );

    bts_fifo #(
        .WIDTH(8),
        .DEPTH(OQ_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_wdata(out_wdata),
        .i_pop  (pop && !empty),
        .o_rdata(o_out_byte),
        .o_empty(empty),
        .o_full (out_full),
        .o_count(out_count)
    );

    `BTS_NEVER(a_mid_overflow, i_clk, i_rst_n, s1.valid && mid_full, "lookup queue overflow")
    `BTS_NEVER(a_out_overflow, i_clk, i_rst_n, out_push && (out_count == OCW'(OQ_DEPTH)), "result queue overflow")
    `BTS_ASSERT(a_clear_issued, i_clk, i_rst_n, (accept && (i_opcode == OP_CLEAR)) |=> s1.valid, "clear not forwarded")
    `BTS_ASSERT(a_pop_needs_item, i_clk, i_rst_n, mid_pop |-> !mid_empty && !out_full, "back end popped without room")

endmodule

// ===== rtl/bts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bts_fifo.sv =====
// Small register queue with count, used between the pipeline parts.
// No dependencies.
module bts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr, n_wptr, n_rptr;
    logic [CW-1:0]    r_count;

    always_comb begin
        n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;

endmodule

// ===== rtl/bts_front.sv =====
// Front end: accepts transactions, keeps mark bits and the target RAM,
// issues lookups. Depends on bts_pkg and bts_ram.
module bts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_opcode,
    input  logic [7:0]     i_byte_value,
    input  logic [7:0]     i_target_value,
    output bts_pkg::t_stage o_s1
);
    import bts_pkg::*;

    localparam int AW = $clog2(TBL_DEPTH);

    logic [TBL_DEPTH-1:0] r_mark;
    logic                 r_valid;
    t_kind                r_kind;
    logic [7:0]           r_value;
    logic                 r_mark_bit;
    logic [7:0]           w_target;
    logic                 w_define, w_data, w_clear;

    assign w_clear  = i_accept && (i_opcode == OP_CLEAR);
    assign w_define = i_accept && (i_opcode == OP_DEFINE);
    assign w_data   = i_accept && (i_opcode == OP_DATA);

    bts_ram #(
        .WIDTH(8),
        .DEPTH(TBL_DEPTH)
    ) u_target_ram (
        .i_clk  (i_clk),
        .i_we   (w_define),
        .i_waddr(i_byte_value[AW-1:0]),
        .i_wdata(i_target_value),
        .i_re   (w_data),
        .i_raddr(i_byte_value[AW-1:0]),
        .o_rdata(w_target)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_clear || w_data;
            if (w_clear) begin
                r_mark <= '0;
            end else if (w_define) begin
                r_mark[i_byte_value[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear || w_data) begin
            r_kind     <= w_clear ? K_CLEAR : K_DATA;
            r_value    <= i_byte_value;
            r_mark_bit <= r_mark[i_byte_value[AW-1:0]];
        end
    end

    always_comb begin
        o_s1.valid       = r_valid;
        o_s1.item.kind   = r_kind;
        o_s1.item.value  = r_value;
        o_s1.item.mark   = r_mark_bit;
        o_s1.item.target = w_target;
    end

endmodule

// ===== rtl/bts_back.sv =====
// Back end: translate, complement, delete and squeeze on queued items.
// Depends on bts_pkg.
module bts_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bts_pkg::t_cfg  i_cfg,
    input  bts_pkg::t_item i_item,
    input  logic          i_empty,
    input  logic          i_out_full,
    output logic          o_pop,
    output logic          o_push,
    output logic [7:0]    o_byte
);
    import bts_pkg::*;

    logic [7:0] r_last;
    logic [7:0] w_tr;
    logic       w_go, w_emit;

    assign w_go = !i_empty && !i_out_full;

    always_comb begin
        if (i_cfg.mode == MODE_TRANSLATE) begin
            w_tr = (i_item.mark && (i_item.target != 8'd0)) ? i_item.target : i_item.value;
        end else if (i_item.value == 8'd0) begin
            w_tr = i_cfg.nul_fill ? i_cfg.fill : 8'd0;
        end else begin
            w_tr = i_item.mark ? i_item.value : i_cfg.fill;
        end

        if (i_item.kind == K_CLEAR) begin
            w_emit = 1'b0;
            o_byte = i_item.value;
        end else if (i_cfg.mode[MODE_DELETE_BIT]) begin
            w_emit = (i_item.value != 8'd0) && !i_item.mark;
            o_byte = i_item.value;
        end else begin
            w_emit = !(i_cfg.squeeze && (w_tr != i_item.value) && (w_tr == r_last));
            o_byte = w_tr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 8'd0;
        end else if (w_go) begin
            if (i_item.kind == K_CLEAR) begin
                r_last <= 8'd0;
            end else if (!i_cfg.mode[MODE_DELETE_BIT] && i_cfg.squeeze) begin
                r_last <= w_tr;
            end
        end
    end

    assign o_pop  = w_go;
    assign o_push = w_go && w_emit;

endmodule

// ===== test/byte_translate_squeeze_delete_tb.sv =====
// Testbench for byte_translate_squeeze_delete: directed and random transactions checked
// against a built-in predictor of the translate, complement, delete and squeeze rules.
// Depends on bts_pkg and the byte_translate_squeeze_delete RTL.
module byte_translate_squeeze_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bts_pkg::*;

    localparam logic [1:0] MODE_COMPLEMENT = 2'd1;
    localparam logic [1:0] MODE_DELETE     = 2'd2;
    localparam logic [1:0] MODE_DELETE_ALT = 2'd3;
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         PHASES          = 12;
    localparam int         ITEMS_PER_PHASE = 150;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [1:0] i_opcode;
    logic [7:0] i_byte_value;
    logic [7:0] i_target_value;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_wdata;

    byte_translate_squeeze_delete uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_byte_value   (i_byte_value),
        .i_target_value (i_target_value),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // predictor state
    t_cfg       cfg_shadow;
    logic [255:0] marked_map;
    logic [7:0] target_map [256];
    logic [7:0] last_translated;
    logic [7:0] pending_bytes [$];

    logic       gaps_on;
    int         mismatch_count;
    logic [7:0] hot_bytes [8];
    logic [7:0] prev_byte;

    always #4 i_clk = ~i_clk;

    initial begin
        i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic void predict_transaction(input logic [1:0] op, input logic [7:0] value,
                                                input logic [7:0] target);
        logic [7:0] mapped;
        case (op)
            OP_CLEAR: begin
                marked_map      = '0;
                last_translated = 8'd0;
            end
            OP_DEFINE: begin
                marked_map[value] = 1'b1;
                target_map[value] = target;
            end
            OP_DATA: begin
                if (cfg_shadow.mode[MODE_DELETE_BIT]) begin
                    if (value != 8'd0 && !marked_map[value]) begin
                        pending_bytes.push_back(value);
                    end
                end else begin
                    if (cfg_shadow.mode == MODE_TRANSLATE) begin
                        mapped = (marked_map[value] && target_map[value] != 8'd0) ?
                                 target_map[value] : value;
                    end else if (value == 8'd0) begin
                        mapped = cfg_shadow.nul_fill ? cfg_shadow.fill : 8'd0;
                    end else begin
                        mapped = marked_map[value] ? value : cfg_shadow.fill;
                    end
                    if (cfg_shadow.squeeze) begin
                        if (!(mapped != value && mapped == last_translated)) begin
                            pending_bytes.push_back(mapped);
                        end
                        last_translated = mapped;
                    end else begin
                        pending_bytes.push_back(mapped);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // push stays high on return; callers that stop sending use stop_sending
    task automatic send_item(input logic [1:0] op, input logic [7:0] value,
                             input logic [7:0] target);
        if (gaps_on) begin
            while ($urandom_range(99) < 23) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push           <= 1'b1;
        i_opcode       <= op;
        i_byte_value   <= value;
        i_target_value <= target;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_transaction(op, value, target);
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        stop_sending();
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic squeeze,
                              input logic nul_fill, input logic [7:0] fill);
        logic [7:0] values [4];
        values[REG_MODE]    = {6'd0, mode};
        values[REG_SQUEEZE] = {7'd0, squeeze};
        values[REG_NUL]     = {7'd0, nul_fill};
        values[REG_FILL]    = fill;
        for (int idx = 0; idx < 4; idx++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[1:0];
            i_cfg_wdata <= values[idx[1:0]];
            @(posedge i_clk);
        end
        i_cfg_we            <= 1'b0;
        cfg_shadow.mode     = mode;
        cfg_shadow.squeeze  = squeeze;
        cfg_shadow.nul_fill = nul_fill;
        cfg_shadow.fill     = fill;
    endtask

    // checks every popped byte against the oldest expected byte
    initial begin
        logic [7:0] wanted;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected out_byte %02h", o_out_byte));
                end else begin
                    wanted = pending_bytes.pop_front();
                    if (o_out_byte !== wanted) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  o_out_byte, wanted));
                    end
                end
            end
            pop <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;
        end
    end

    task automatic test_translate();
        set_config(MODE_TRANSLATE, 1'b0, 1'b0, 8'h00);
        send_item(OP_DEFINE, 8'h41, 8'h61);
        send_item(OP_DEFINE, 8'hFF, 8'h00);
        send_item(OP_DEFINE, 8'h00, 8'hFF);
        send_item(OP_DATA, 8'h41, 8'hFF);
        send_item(OP_DATA, 8'hFF, 8'h00);
        send_item(OP_DATA, 8'h00, 8'hFF);
        send_item(OP_DATA, 8'h80, 8'($urandom));
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
        send_item(OP_CLEAR, 8'hFF, 8'hFF);
        send_item(OP_DATA, 8'h41, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_complement();
        set_config(MODE_COMPLEMENT, 1'b0, 1'b1, 8'hFF);
        send_item(OP_DEFINE, 8'h00, 8'h12);
        send_item(OP_DEFINE, 8'h7E, 8'h34);
        send_item(OP_DATA, 8'h00, 8'($urandom));
        send_item(OP_DATA, 8'h7E, 8'($urandom));
        send_item(OP_DATA, 8'h01, 8'($urandom));
        wait_idle();
        set_config(MODE_COMPLEMENT, 1'b0, 1'b0, 8'h2A);
        send_item(OP_DATA, 8'h00, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_squeeze();
        set_config(MODE_TRANSLATE, 1'b1, 1'b0, 8'h00);
        send_item(OP_CLEAR, 8'h00, 8'h00);
        send_item(OP_DEFINE, 8'h61, 8'h78);
        send_item(OP_DEFINE, 8'h62, 8'h78);
        send_item(OP_DATA, 8'h61, 8'($urandom));
        send_item(OP_DATA, 8'h62, 8'($urandom));
        send_item(OP_DATA, 8'h78, 8'($urandom));
        send_item(OP_DATA, 8'h78, 8'($urandom));
        send_item(OP_DATA, 8'h61, 8'($urandom));
        wait_idle();
    endtask

    task automatic test_delete();
        set_config(MODE_DELETE, 1'b1, 1'b1, 8'hFF);
        send_item(OP_DATA, 8'h00, 8'($urandom));
        send_item(OP_DATA, 8'h61, 8'($urandom));
        send_item(OP_DATA, 8'h63, 8'($urandom));
        wait_idle();
        set_config(MODE_DELETE_ALT, 1'b0, 1'b0, 8'h00);
        send_item(OP_DATA, 8'h62, 8'($urandom));
        send_item(OP_DATA, 8'h63, 8'($urandom));
        wait_idle();
    endtask

    function automatic logic [7:0] pick_data_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return hot_bytes[3'($urandom_range(7))];
        if (roll < 45) return 8'h00;
        if (roll < 52) return 8'hFF;
        if (roll < 67) return prev_byte;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_target();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20) return 8'h00;
        if (roll < 30) return 8'hFF;
        if (roll < 70) return hot_bytes[3'($urandom_range(3))];
        return 8'($urandom);
    endfunction

    task automatic send_random_item();
        int         roll;
        logic [7:0] value;
        roll = $urandom_range(99);
        if (roll < 70) begin
            value = pick_data_byte();
            send_item(OP_DATA, value, 8'($urandom));
            prev_byte = value;
        end else if (roll < 92) begin
            value = ($urandom_range(3) != 0) ? hot_bytes[3'($urandom_range(7))]
                                             : 8'($urandom);
            send_item(OP_DEFINE, value, pick_target());
        end else if (roll < 96) begin
            send_item(OP_CLEAR, 8'($urandom), 8'($urandom));
        end else begin
            send_item(OP_UNUSED, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_streams();
        logic [7:0] fill;
        logic       squeeze;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       fill = 8'h00;
                1:       fill = 8'hFF;
                default: fill = 8'($urandom);
            endcase
            squeeze = (phase < 8) ? 1'((phase / 4) % 2 == 0) : 1'($urandom_range(1));
            set_config(2'(phase % 4), squeeze, 1'($urandom_range(1)), fill);
            gaps_on = (phase != 5);
            for (int k = 0; k < 8; k++) begin
                hot_bytes[k] = 8'($urandom);
            end
            prev_byte = hot_bytes[0];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random_item();
                if ($urandom_range(199) == 0) begin
                    wait_results_done();
                end
            end
            gaps_on = 1'b1;
            wait_idle();
        end
    endtask

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        mismatch_count  = 0;
        gaps_on         = 1'b1;
        cfg_shadow      = '0;
        marked_map      = '0;
        last_translated = 8'd0;
        prev_byte       = 8'd0;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_opcode       <= OP_CLEAR;
        i_byte_value   <= 8'd0;
        i_target_value <= 8'd0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_MODE;
        i_cfg_wdata    <= 8'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_translate();
        test_complement();
        test_squeeze();
        test_delete();
        test_random_streams();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
